// File: design/octg_pkg.sv
// Shared constants for the output-compare tone generator.
package octg_pkg;

  // Command opcodes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_FREQ = 2'd1;
  localparam logic [1:0] OP_STOP     = 2'd2;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int TONE_W   = 20;
  localparam int HALF_W   = 32;
  localparam int CLK_W    = 32;

  // Divider operand widths: dividend is the timer clock, divisor is 2 * tone
  localparam int DVD_W = CLK_W;
  localparam int DVS_W = TONE_W + 1;

  // Free-running counter width default
  localparam int CNT_WIDTH_DEF = 32;

  // Configuration register map
  localparam int          PADDR_W       = 2;
  localparam int          PDATA_W       = 32;
  localparam logic [31:0] CLK_HZ_RESET  = 32'd1000000;
  localparam logic [PADDR_W-1:0] ADDR_TIMER_CLOCK_HZ = 2'd0;

endpackage

// File: design/octg_if.sv
// Valid/ready channel interfaces for commands and results.
interface octg_cmd_if import octg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [TONE_W-1:0]   tone_hz;

  modport source (output valid, output opcode, output tone_hz, input ready);
  modport sink   (input valid, input opcode, input tone_hz, output ready);
endinterface

interface octg_result_if import octg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              tone_level;
  logic              running;
  logic              match_event;
  logic [HALF_W-1:0] half_period_ticks;

  modport source (output valid, output tone_level, output running, output match_event,
                  output half_period_ticks, input ready);
  modport sink   (input valid, input tone_level, input running, input match_event,
                  input half_period_ticks, output ready);
endinterface

// File: design/octg_cfg_regs.sv
// APB register block holding the timer clock frequency.
module octg_cfg_regs import octg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CLK_W-1:0]   timer_clock_hz
);

  logic wr_en;

  // Decode the access phase of a write; byte lanes inside the word are ignored
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Hold the register
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= CLK_HZ_RESET;
    end else if (wr_en) begin
      timer_clock_hz <= pwdata[CLK_W-1:0];
    end
  end

  // Read back
  assign prdata = timer_clock_hz;

endmodule

// File: design/octg_divider.sv
// Restoring divider, one quotient bit per cycle, for the half-period computation.
module octg_divider import octg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              q_bit;
  logic [DVS_W-1:0]  rem_next;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, quotient[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    q_bit   = ~diff[DVS_W+1];
    rem_next = q_bit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[DVD_W-2:0], q_bit};
    end
  end

endmodule

// File: design/output_compare_tone_generator.sv
// Top level of the output-compare square-wave tone generator.
// A tick, stop or unused-opcode transaction is taken while idle and its result is
// registered at the accepting edge; back-to-back ticks run at one per cycle as long as the
// result side keeps up. A set-frequency transaction with a nonzero tone runs the half
// period timer_clock_hz / (2 * tone_hz) through a restoring divider that produces
// one quotient bit per cycle, so the block stays busy through the 32 divide steps,
// the commit and the result load before it takes the next transaction. Frequency
// zero acts as a stop. The timer clock frequency is written through the APB port,
// which ignores paddr, and should only change while the block is idle.
module output_compare_tone_generator import octg_pkg::*; #(
  parameter int COUNTER_WIDTH = CNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  octg_cmd_if.sink           cmd,
  octg_result_if.source      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]               state;
  logic [COUNTER_WIDTH-1:0] free_counter;
  logic [COUNTER_WIDTH-1:0] compare_value;
  logic [HALF_W-1:0]        half_period;
  logic                     active_flag;
  logic                     pin_level;

  logic                     out_valid;
  logic                     out_level;
  logic                     out_running;
  logic                     out_match;
  logic [HALF_W-1:0]        out_half;

  logic [CLK_W-1:0]         timer_clock_hz;
  logic                     div_start;
  logic                     div_done;
  logic [DVD_W-1:0]         div_quot;

  logic                     slot_free;
  logic                     cmd_acc;
  logic [COUNTER_WIDTH-1:0] cnt_inc;
  logic                     hit;

  octg_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .timer_clock_hz (timer_clock_hz)
  );

  octg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timer_clock_hz),
    .divisor  ({cmd.tone_hz, 1'b0}),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Handshake: take a transaction only when idle and the result slot can be reused
  assign slot_free = !out_valid || result.ready;
  assign cmd.ready = (state == ST_IDLE) && slot_free;
  assign cmd_acc   = cmd.valid && cmd.ready;

  // Tick compare
  assign cnt_inc = free_counter + COUNTER_WIDTH'(1);
  assign hit     = active_flag && (cnt_inc == compare_value);

  // Kick the divider for a nonzero set-frequency
  assign div_start = cmd_acc && (cmd.opcode == OP_SET_FREQ) && (cmd.tone_hz != '0);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      free_counter  <= '0;
      compare_value <= '0;
      half_period   <= '0;
      active_flag   <= 1'b0;
      pin_level     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Drop the result once taken
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            case (cmd.opcode)
              OP_TICK: begin
                free_counter <= cnt_inc;
                if (hit) begin
                  pin_level     <= ~pin_level;
                  compare_value <= compare_value + half_period[COUNTER_WIDTH-1:0];
                end
                out_valid <= 1'b1;
              end
              OP_SET_FREQ: begin
                if (cmd.tone_hz == '0) begin
                  active_flag <= 1'b0;
                  out_valid   <= 1'b1;
                end else begin
                  state <= ST_DIV;
                end
              end
              OP_STOP: begin
                active_flag <= 1'b0;
                out_valid   <= 1'b1;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_DIV: begin
          // Commit the new half period; restart the compare only from idle
          if (div_done) begin
            half_period <= div_quot;
            if (!active_flag) begin
              active_flag   <= 1'b1;
              compare_value <= free_counter + div_quot[COUNTER_WIDTH-1:0];
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload: load from the post-transaction state
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_acc) begin
      out_match <= (cmd.opcode == OP_TICK) && hit;
      out_half  <= half_period;
      case (cmd.opcode)
        OP_TICK: begin
          out_level   <= pin_level ^ hit;
          out_running <= active_flag;
        end
        OP_SET_FREQ, OP_STOP: begin
          out_level   <= pin_level;
          out_running <= 1'b0;
        end
        default: begin
          out_level   <= pin_level;
          out_running <= active_flag;
        end
      endcase
    end else if (state == ST_EMIT && slot_free) begin
      out_match   <= 1'b0;
      out_half    <= half_period;
      out_level   <= pin_level;
      out_running <= active_flag;
    end
  end

  assign result.valid             = out_valid;
  assign result.tone_level        = out_level;
  assign result.running           = out_running;
  assign result.match_event       = out_match;
  assign result.half_period_ticks = out_half;

endmodule

// File: design/octg_checker.sv
// Port-level assertions for the tone generator, bound to the top level.
module octg_checker import octg_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic [OPCODE_W-1:0] cmd_opcode,
  input logic [TONE_W-1:0]   cmd_tone_hz,
  input logic                res_valid,
  input logic                res_ready,
  input logic                res_running,
  input logic                res_match,
  input logic [HALF_W-1:0]   res_half
);

  // Stalled result holds
  property p_res_hold;
    @(posedge clk) disable iff (rst)
      res_valid && !res_ready |=> res_valid && $stable(res_half) && $stable(res_running);
  endproperty
  a_res_hold: assert property (p_res_hold) else $error("stalled result changed");

  // A match is reported only while the tone runs
  property p_match_running;
    @(posedge clk) disable iff (rst) res_valid && res_match |-> res_running;
  endproperty
  a_match_running: assert property (p_match_running) else $error("match while stopped");

  // Commands are taken only when the result slot can be reused
  property p_ready_slot;
    @(posedge clk) disable iff (rst) cmd_ready |-> !res_valid || res_ready;
  endproperty
  a_ready_slot: assert property (p_ready_slot) else $error("ready with result blocked");

  // A stop yields a stopped result on the next cycle
  property p_stop_result;
    @(posedge clk) disable iff (rst)
      cmd_valid && cmd_ready && cmd_opcode == OP_STOP |=> res_valid && !res_running;
  endproperty
  a_stop_result: assert property (p_stop_result) else $error("stop result missing");

  // A nonzero set-frequency keeps the block busy while dividing
  property p_set_busy;
    @(posedge clk) disable iff (rst)
      cmd_valid && cmd_ready && cmd_opcode == OP_SET_FREQ && cmd_tone_hz != '0
      |=> !cmd_ready;
  endproperty
  a_set_busy: assert property (p_set_busy) else $error("ready during divide");

endmodule

bind output_compare_tone_generator octg_checker u_octg_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_opcode  (cmd.opcode),
  .cmd_tone_hz (cmd.tone_hz),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_running (result.running),
  .res_match   (result.match_event),
  .res_half    (result.half_period_ticks)
);
